@@ src/nits_pkg.sv @@
// Shared types and constants of the nested interval timer stack.
`timescale 1ns / 1ps

package nits_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam int SLOT_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int STAMP_W = 64;
    localparam int RATE_W = 32;
    localparam int INTERVAL_W = 32;
    localparam int FLAGS_W = 4;
    localparam int UNIT_W = STAMP_W + 1;

    localparam int MUL_STEPS = RATE_W;
    localparam int DIV_STEPS = STAMP_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [STAMP_W-1:0] FREQ_RESET = 64'd1000000;

    localparam int FLAG_PUSH = 0;
    localparam int FLAG_READ = 1;
    localparam int FLAG_SET = 2;
    localparam int FLAG_POP = 3;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic en;
        logic [SLOT_W-1:0] slot;
        logic [STAMP_W-1:0] data;
    } stamp_wr_t;

endpackage

@@ src/nested_interval_timer_stack.sv @@
// Top level of the nested interval timer stack with its step sequencer.
//
//  Channel   Direction  Payload
//  s_axis    in         tuser = op_flags, tdata = counter_now, scale_rate
//  m_axis    out        tdata = interval, tuser = status
//  cfg       in         cfg_wr_data = counter_frequency
//
// A rejected request goes straight to the done state, an accepted one without a scaled read through the elapsed step.
// A scaled read runs one subtract, 32 multiply steps and 64 divide steps,
// all through the one shared 65-bit add and subtract unit.
// Reset clears the stack level and all saved timestamps at once.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module nested_interval_timer_stack
    import nits_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [95:0]        s_axis_tdata,   // counter_now[63:0], scale_rate[95:64]
    input  logic [3:0]         s_axis_tuser,   // op_flags[3:0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,   // interval[31:0]
    output logic [1:0]         m_axis_tuser,   // status[1:0]
    input  logic               cfg_wr_en,
    input  logic [63:0]        cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [STAMP_W-1:0]     freq_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [FLAGS_W-1:0]     flags_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [STAMP_W-1:0]     now_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic [STAMP_W-1:0]     acc_reg;
    logic [STAMP_W-1:0]     mcand_reg;
    logic [STAMP_W-1:0]     rem_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [INTERVAL_W-1:0]  res_interval_reg;
    status_t                res_status_reg;
    logic                   out_valid_reg;
    logic [INTERVAL_W-1:0]  out_interval_reg;
    logic [1:0]             out_status_reg;

    logic                   in_push;
    logic                   in_overflow;
    logic                   in_empty;
    logic [LEVEL_W-1:0]     in_level;
    logic [SLOT_W-1:0]      in_slot;
    logic [LEVEL_W-1:0]     level_next;

    stamp_wr_t              stamp_wr;
    logic [STAMP_W-1:0]     stamp_rd;

    logic [UNIT_W-1:0]      unit_a;
    logic [UNIT_W-1:0]      unit_b;
    logic                   unit_sub;
    logic [UNIT_W-1:0]      unit_sum;
    logic                   unit_carry;

    nits_stamp_file u_stamp_file (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (stamp_wr),
        .rd_slot (slot_reg),
        .rd_data (stamp_rd)
    );

    nits_addsub u_addsub (
        .a     (unit_a),
        .b     (unit_b),
        .sub   (unit_sub),
        .sum   (unit_sum),
        .carry (unit_carry)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_interval_reg;
    assign m_axis_tuser = out_status_reg;

    always_comb
    begin
        in_push = s_axis_tuser[FLAG_PUSH];
        in_overflow = in_push && (level_reg >= LEVEL_W'(STACK_DEPTH));
        in_empty = !in_push && (level_reg == '0);
        in_level = level_reg + LEVEL_W'(in_push);
        in_slot = SLOT_W'(in_level - LEVEL_W'(1));
        level_next = level_reg + LEVEL_W'(flags_reg[FLAG_PUSH])
                     - LEVEL_W'(flags_reg[FLAG_POP]);
    end

    always_comb
    begin
        stamp_wr.en = (state_reg == ST_ELAPSED) && flags_reg[FLAG_SET];
        stamp_wr.slot = slot_reg;
        stamp_wr.data = now_reg;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_MUL:
            begin
                unit_a = {1'b0, acc_reg};
                unit_b = rate_reg[0] ? {1'b0, mcand_reg} : '0;
                unit_sub = 1'b0;
            end
            ST_DIV:
            begin
                unit_a = {rem_reg, acc_reg[STAMP_W-1]};
                unit_b = {1'b0, freq_reg};
                unit_sub = 1'b1;
            end
            default:
            begin
                unit_a = {1'b0, now_reg};
                unit_b = {1'b0, stamp_rd};
                unit_sub = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_RESET;
        end
        else if (cfg_wr_en)
        begin
            freq_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= '0;
            flags_reg <= '0;
            slot_reg <= '0;
            now_reg <= '0;
            rate_reg <= '0;
            acc_reg <= '0;
            mcand_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
            res_interval_reg <= '0;
            res_status_reg <= STATUS_OK;
            out_valid_reg <= 1'b0;
            out_interval_reg <= '0;
            out_status_reg <= '0;
        end
        else
        begin
            if (m_axis_tready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        flags_reg <= s_axis_tuser;
                        now_reg <= s_axis_tdata[63:0];
                        rate_reg <= s_axis_tdata[95:64];
                        slot_reg <= in_slot;
                        res_interval_reg <= '0;
                        if (in_overflow)
                        begin
                            res_status_reg <= STATUS_OVERFLOW;
                            state_reg <= ST_DONE;
                        end
                        else if (in_empty)
                        begin
                            res_status_reg <= STATUS_EMPTY;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            res_status_reg <= STATUS_OK;
                            state_reg <= ST_ELAPSED;
                        end
                    end
                end
                ST_ELAPSED:
                begin
                    level_reg <= level_next;
                    mcand_reg <= unit_sum[STAMP_W-1:0];
                    acc_reg <= '0;
                    cnt_reg <= '0;
                    if (!flags_reg[FLAG_READ])
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (rate_reg == '0)
                    begin
                        res_interval_reg <= unit_sum[INTERVAL_W-1:0];
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    acc_reg <= unit_sum[STAMP_W-1:0];
                    mcand_reg <= {mcand_reg[STAMP_W-2:0], 1'b0};
                    rate_reg <= {1'b0, rate_reg[RATE_W-1:1]};
                    if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                    begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= unit_carry ? unit_sum[STAMP_W-1:0] : unit_a[STAMP_W-1:0];
                    acc_reg <= {acc_reg[STAMP_W-2:0], unit_carry};
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        res_interval_reg <= {acc_reg[INTERVAL_W-2:0], unit_carry};
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_interval_reg <= res_interval_reg;
                        out_status_reg <= res_status_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_W'(STACK_DEPTH))
        else $error("Stack level exceeds the stack depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != 2'(STATUS_OK))) |-> (m_axis_tdata == '0))
        else $error("A failed transaction carries a nonzero interval.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg != $past(level_reg)) |-> ($past(state_reg) == ST_ELAPSED))
        else $error("Stack level changed outside the update step.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> ((state_reg == ST_MUL) || (state_reg == ST_DIV)))
        else $error("Multiply steps left before the divide.");

endmodule

@@ src/nits_addsub.sv @@
// Shared add and subtract unit used for elapsed time, multiply and divide steps.
`timescale 1ns / 1ps

module nits_addsub
    import nits_pkg::*;
(
    input  logic [UNIT_W-1:0] a,
    input  logic [UNIT_W-1:0] b,
    input  logic              sub,
    output logic [UNIT_W-1:0] sum,
    output logic              carry
);

    logic [UNIT_W:0] full;

    assign full = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (UNIT_W + 1)'(sub);
    assign sum = full[UNIT_W-1:0];
    assign carry = full[UNIT_W];

endmodule

@@ src/nits_stamp_file.sv @@
// Register file of saved timestamps, one entry per stack level.
`timescale 1ns / 1ps

module nits_stamp_file
    import nits_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  stamp_wr_t          wr,
    input  logic [SLOT_W-1:0]  rd_slot,
    output logic [STAMP_W-1:0] rd_data
);

    logic [STAMP_W-1:0] stamps_reg [STACK_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stamps_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            stamps_reg[wr.slot] <= wr.data;
        end
    end

    assign rd_data = stamps_reg[rd_slot];

endmodule

@@ verif/nested_interval_timer_stack_tb.sv @@
// Self-checking testbench for the nested interval timer stack, with its own model of the stack.
`timescale 1ns / 1ps

module nested_interval_timer_stack_tb
    import nits_pkg::*;
();

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        status_t status;
    } timer_reading_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic [3:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;

    logic [STAMP_W-1:0] stamp_mem [STACK_DEPTH];
    int depth_used = 0;
    logic [STAMP_W-1:0] tick_freq = FREQ_RESET;
    logic [STAMP_W-1:0] wall_ticks = '0;
    timer_reading_t awaited_readings[$];

    int fail_count = 0;
    int requests_sent = 0;
    int readings_checked = 0;
    int freq_writes = 0;
    int burst_left = 0;
    int tx_gap_max = 0;
    int rx_stall_pct = 0;
    int rx_stall_left = 0;
    int rx_hold = 0;

    nested_interval_timer_stack u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        foreach (stamp_mem[i])
        begin
            stamp_mem[i] = '0;
        end
    end

    function automatic logic [3:0] op_mask(bit do_push, bit do_read, bit do_set, bit do_pop);
        logic [3:0] m;
        m = '0;
        m[FLAG_PUSH] = do_push;
        m[FLAG_READ] = do_read;
        m[FLAG_SET] = do_set;
        m[FLAG_POP] = do_pop;
        return m;
    endfunction

    function automatic timer_reading_t compute_interval(logic [3:0] flags,
                                                        logic [STAMP_W-1:0] now,
                                                        logic [RATE_W-1:0] rate);
        timer_reading_t r;
        int lvl;
        int slot;
        logic [STAMP_W-1:0] elapsed;
        logic [STAMP_W-1:0] prod;
        r.interval = '0;
        r.status = STATUS_OK;
        lvl = depth_used;
        if (flags[FLAG_PUSH])
        begin
            if (lvl >= STACK_DEPTH)
            begin
                r.status = STATUS_OVERFLOW;
                return r;
            end
            lvl++;
        end
        else if (lvl == 0)
        begin
            r.status = STATUS_EMPTY;
            return r;
        end
        slot = lvl - 1;
        elapsed = '0;
        if (flags[FLAG_READ])
        begin
            elapsed = now - stamp_mem[slot];
            if (rate != 0)
            begin
                prod = elapsed * {32'd0, rate};
                elapsed = (tick_freq == 0) ? '1 : prod / tick_freq;
            end
        end
        if (flags[FLAG_SET])
        begin
            stamp_mem[slot] = now;
        end
        if (flags[FLAG_POP])
        begin
            lvl--;
        end
        depth_used = lvl;
        r.interval = elapsed[INTERVAL_W-1:0];
        return r;
    endfunction

    task automatic send_request(input logic [3:0] flags, input logic [STAMP_W-1:0] now,
                                input logic [RATE_W-1:0] rate);
        int gap;
        gap = 0;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, tx_gap_max);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {rate, now};
        s_axis_tuser <= flags;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        awaited_readings.push_back(compute_interval(flags, now, rate));
        burst_left--;
        requests_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_readings.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_frequency(input logic [STAMP_W-1:0] freq);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= freq;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        tick_freq = freq;
        freq_writes++;
    endtask

    task automatic pick_request(output logic [3:0] flags, output logic [STAMP_W-1:0] now,
                                output logic [RATE_W-1:0] rate);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            flags = 4'($urandom_range(0, 15));
        else if (depth_used == 0)
            flags = op_mask(1'b1, $urandom_range(0, 3) == 0, 1'b1, 1'b0);
        else if (roll < 38)
            flags = op_mask(1'b1, $urandom_range(0, 3) == 0, 1'b1, 1'b0);
        else if (roll < 60)
            flags = op_mask(1'b0, 1'b1, $urandom_range(0, 2) == 0, 1'b0);
        else if (roll < 78)
            flags = op_mask(1'b0, 1'b1, 1'b0, 1'b1);
        else if (roll < 86)
            flags = op_mask(1'b0, 1'b0, 1'b1, 1'b0);
        else if (roll < 93)
            flags = op_mask(1'b0, 1'b0, 1'b0, 1'b1);
        else
            flags = op_mask(1'b1, $urandom_range(0, 1) == 1, 1'b1, 1'b1);

        roll = $urandom_range(0, 99);
        if (roll < 5)
            wall_ticks = {$urandom, $urandom};
        else if (roll < 15)
            wall_ticks = wall_ticks + {32'd0, $urandom};
        else
            wall_ticks = wall_ticks + 64'($urandom_range(0, 5000));
        now = wall_ticks;

        roll = $urandom_range(0, 99);
        if (roll < 25)
            rate = '0;
        else if (roll < 45)
            rate = $urandom_range(1, 1000);
        else if (roll < 60)
            rate = (roll < 50) ? 32'd1000 : (roll < 55) ? 32'd1000000 : 32'd1000000000;
        else
            rate = $urandom;
    endtask

    task automatic test_empty_stack();
        send_request(op_mask(1'b0, 1'b0, 1'b0, 1'b0), 64'd5, 32'd0);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b0), 64'd9, 32'd7);
        send_request(op_mask(1'b0, 1'b1, 1'b1, 1'b1), '1, '1);
    endtask

    task automatic test_fill_and_overflow();
        send_request(op_mask(1'b1, 1'b0, 1'b1, 1'b0), 64'd0, 32'd0);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b0), '1, 32'd0);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b0), '1, '1);
        send_request(op_mask(1'b1, 1'b1, 1'b1, 1'b1), 64'h8000_0000_0000_0000, 32'd1000);
        send_request(op_mask(1'b0, 1'b1, 1'b1, 1'b0), 64'h0000_0001_0000_0003, 32'd0);
        for (int i = 1; i < STACK_DEPTH; i++)
        begin
            send_request(op_mask(1'b1, 1'b0, 1'b1, 1'b0), 64'd1000 * i, 32'd0);
        end
        send_request(op_mask(1'b1, 1'b1, 1'b0, 1'b0), 64'd99999, 32'd5);
        send_request(op_mask(1'b1, 1'b0, 1'b0, 1'b1), 64'd99999, 32'd5);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b0), 64'd20000, 32'd1000000);
    endtask

    task automatic test_zero_frequency();
        wait_drained();
        write_frequency('0);
        send_request(op_mask(1'b1, 1'b0, 1'b1, 1'b0), 64'd300, 32'd0);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b0), 64'd900, 32'd3);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b1), 64'd901, 32'd0);
    endtask

    task automatic test_frequency_extremes();
        wait_drained();
        write_frequency(64'd1);
        send_request(op_mask(1'b1, 1'b0, 1'b1, 1'b0), 64'd100, 32'd0);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b0), 64'h0000_0001_2345_6789, '1);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b1), '1, 32'd77);
        wait_drained();
        write_frequency('1);
        send_request(op_mask(1'b1, 1'b0, 1'b1, 1'b0), 64'd1, 32'd0);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b0), '1, '1);
        send_request(op_mask(1'b0, 1'b1, 1'b0, 1'b1), 64'd0, 32'h8000_0000);
    endtask

    task automatic test_random_nesting(input int n_items);
        logic [3:0] flags;
        logic [STAMP_W-1:0] now;
        logic [RATE_W-1:0] rate;
        for (int i = 0; i < n_items; i++)
        begin
            pick_request(flags, now, rate);
            send_request(flags, now, rate);
        end
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        tx_gap_max = 0;
        rx_stall_pct = 0;
        @(posedge clk);
        rx_hold = 400;
        test_random_nesting(16);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left = rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < rx_stall_pct)
        begin
            rx_stall_left = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        timer_reading_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_readings.size() == 0)
            begin
                $error("unexpected transaction: interval=%0h status=%0d",
                       m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = awaited_readings.pop_front();
                readings_checked++;
                if (m_axis_tdata !== want.interval)
                begin
                    $error("interval: expected %0h, actual %0h", want.interval, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [STAMP_W-1:0] freq;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_empty_stack();
        test_fill_and_overflow();
        test_zero_frequency();
        test_frequency_extremes();

        for (int p = 0; p < 5; p++)
        begin
            wait_drained();
            case (p % 3)
                0: freq = {$urandom, $urandom};
                1: freq = 64'($urandom_range(1, 1000));
                default: freq = 64'd1000000000;
            endcase
            write_frequency(freq);
            tx_gap_max = (p == 0) ? 0 : $urandom_range(1, 8);
            rx_stall_pct = (p == 0) ? 0 : $urandom_range(5, 40);
            test_random_nesting(250);
        end

        test_output_backpressure();
        write_frequency(FREQ_RESET);
        tx_gap_max = 4;
        rx_stall_pct = 20;
        test_random_nesting(40);
        wait_drained();
        repeat (120) @(negedge clk);

        $display("Sent %0d requests across %0d frequency settings, %0d transactions checked.",
                 requests_sent, freq_writes + 1, readings_checked);
        $display("Runs covered empty stack, overflow, zero frequency and long output stalls.");
        if (fail_count == 0 && awaited_readings.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
